// ----- rtl/core/evg_pkg.sv -----
package evg_pkg;

   localparam int unsigned BufferSamples = 65536;

   localparam int unsigned SampleWidth   = 16;
   localparam int unsigned MagWidth      = 17;
   localparam int unsigned SumWidth      = 28;
   localparam int unsigned StrengthWidth = 5;
   localparam int unsigned ChunkWidth    = 13;
   localparam int unsigned FillWidth     = 12;
   localparam int unsigned TotalWidth    = 17;
   localparam int unsigned HangWidth     = 9;
   localparam int unsigned CountWidth    = 8;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 13;
   localparam int unsigned ReqDataWidth  = 16;
   localparam int unsigned RspDataWidth  = 48;

   localparam logic [ChunkWidth-1:0] ChunkMax = ChunkWidth'(4096);

   localparam logic [CsrIndexWidth-1:0] CsrChunkSamples     = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrStrengthThresh   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrHangoverChunks   = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CsrMinSessionChunks = 2'd3;

   localparam logic OpSample = 1'b0;
   localparam logic OpStop   = 1'b1;

   typedef struct packed {
      logic [ChunkWidth-1:0]    chunk_samples;
      logic [StrengthWidth-1:0] strength_threshold;
      logic [CountWidth-1:0]    hangover_chunks;
      logic [CountWidth-1:0]    min_session_chunks;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      chunk_samples:      ChunkWidth'(1152),
      strength_threshold: StrengthWidth'(22),
      hangover_chunks:    CountWidth'(10),
      min_session_chunks: CountWidth'(15)
   };

   typedef struct packed {
      logic                operation;
      logic [MagWidth-1:0] mag;
   } item_type;

   typedef struct packed {
      logic [StrengthWidth-1:0] strength;
      logic                     voiced;
      logic                     session_end;
      logic                     keep;
      logic [TotalWidth-1:0]    session_samples;
      logic [TotalWidth-1:0]    session_chunks;
   } report_type;

   function automatic logic [StrengthWidth-1:0] bit_length(input logic [SumWidth-1:0] v);
      logic [StrengthWidth-1:0] n;
      n = '0;
      for (int i = 0; i < SumWidth; i++) begin
         if (v[i]) begin
            n = StrengthWidth'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

// ----- rtl/core/energy_voice_gate_hangover.sv -----
// Path: an accepted word goes into the input register; the single stage behind it
// registers the updated session state and, at a chunk end or stop, the report.
// Throughput: one word a cycle unless a reporting word waits on rsp_tready; a
// chunk's magnitude sum, strength and session update all complete in that stage.
// Reset: synchronous, active high; clears all session state and restores the
// register defaults (1152 samples, threshold 22, hangover 10, minimum 15).
module energy_voice_gate_hangover (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [evg_pkg::ReqDataWidth-1:0]    req_tdata,  // sample[15:0]
   input  logic                                req_tuser,  // operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // strength[4:0], voiced[5], keep[6], session_samples[23:7],
   // session_chunks[40:24], zero[47:41]
   output logic [evg_pkg::RspDataWidth-1:0]    rsp_tdata,
   output logic                                rsp_tlast,  // session_end
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [evg_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [evg_pkg::CsrDataWidth-1:0]    csr_data
);

   evg_pkg::cfg_type     cfg_ff, cfg_in;
   evg_pkg::item_type    item;
   evg_pkg::report_type  report;
   logic                 item_valid;
   logic                 consume;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            evg_pkg::CsrChunkSamples:
               cfg_in.chunk_samples = csr_data;
            evg_pkg::CsrStrengthThresh:
               cfg_in.strength_threshold = csr_data[evg_pkg::StrengthWidth-1:0];
            evg_pkg::CsrHangoverChunks:
               cfg_in.hangover_chunks = csr_data[evg_pkg::CountWidth-1:0];
            evg_pkg::CsrMinSessionChunks:
               cfg_in.min_session_chunks = csr_data[evg_pkg::CountWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= evg_pkg::CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   evg_ingress u_ingress (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .consume    (consume),
      .item_valid (item_valid),
      .item       (item)
   );

   evg_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .consume    (consume),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .report     (report)
   );

   assign rsp_tdata = {7'b0, report.session_chunks, report.session_samples,
                       report.keep, report.voiced, report.strength};
   assign rsp_tlast = report.session_end;

`ifndef SYNTH
   a_keep_needs_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !report.session_end |-> !report.keep)
      else $error("keep set on a report that does not close the session");

   a_keep_has_samples: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && report.keep |-> report.session_samples != '0)
      else $error("kept session holds no samples");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> item_valid && rsp_tvalid && !rsp_tready)
      else $error("input stalled without a waiting result");

   a_no_chunks_no_samples: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && report.session_chunks == '0 |-> report.session_samples == '0)
      else $error("session samples without chunks");
`endif

endmodule

// ----- rtl/core/evg_ingress.sv -----
module evg_ingress (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [evg_pkg::ReqDataWidth-1:0]    req_tdata,
   input  logic                                req_tuser,
   input  logic                                consume,
   output logic                                item_valid,
   output evg_pkg::item_type                   item
);

   logic                       valid_ff;
   logic                       valid_in;
   evg_pkg::item_type          item_ff;
   evg_pkg::item_type          item_in;
   logic signed [evg_pkg::MagWidth-1:0] wide;

   assign req_tready = !valid_ff || consume;

   always_comb begin
      wide = {req_tdata[evg_pkg::SampleWidth-1], req_tdata};
      item_in.operation = req_tuser;
      item_in.mag = wide[evg_pkg::MagWidth-1] ? evg_pkg::MagWidth'(-wide)
                                              : evg_pkg::MagWidth'(wide);
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- rtl/core/evg_core.sv -----
module evg_core (
   input  logic                  clock,
   input  logic                  reset,
   input  evg_pkg::cfg_type      cfg,
   input  logic                  item_valid,
   input  evg_pkg::item_type     item,
   output logic                  consume,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output evg_pkg::report_type   report
);

   localparam logic [evg_pkg::TotalWidth:0] BufferLimit =
      (evg_pkg::TotalWidth + 1)'(evg_pkg::BufferSamples);
   localparam logic signed [evg_pkg::HangWidth-1:0] HangFloor =
      {1'b1, {(evg_pkg::HangWidth-1){1'b0}}};

   logic [evg_pkg::SumWidth-1:0]          abs_sum_ff, abs_sum_in;
   logic [evg_pkg::FillWidth-1:0]         fill_ff, fill_in;
   logic [evg_pkg::TotalWidth-1:0]        samples_ff, samples_in;
   logic [evg_pkg::TotalWidth-1:0]        chunks_ff, chunks_in;
   logic signed [evg_pkg::HangWidth-1:0]  hang_ff, hang_in;
   logic                                  valid_ff, valid_in;
   evg_pkg::report_type                   report_ff, report_in;

   logic [evg_pkg::ChunkWidth-1:0]        chunk_eff;
   logic [evg_pkg::ChunkWidth-1:0]        fill_inc;
   logic [evg_pkg::SumWidth-1:0]          sum_next;
   logic [evg_pkg::StrengthWidth-1:0]     strength;
   logic                                  voiced;
   logic signed [evg_pkg::HangWidth-1:0]  hang_next;
   logic [evg_pkg::TotalWidth-1:0]        samples_next;
   logic [evg_pkg::TotalWidth-1:0]        chunks_next;
   logic [evg_pkg::TotalWidth:0]          room;
   logic                                  chunk_done;
   logic                                  produce;
   logic                                  out_free;
   logic                                  ends;

   always_comb begin
      if (cfg.chunk_samples == '0) begin
         chunk_eff = evg_pkg::ChunkWidth'(1);
      end else if (cfg.chunk_samples > evg_pkg::ChunkMax) begin
         chunk_eff = evg_pkg::ChunkMax;
      end else begin
         chunk_eff = cfg.chunk_samples;
      end

      fill_inc   = {1'b0, fill_ff} + evg_pkg::ChunkWidth'(1);
      sum_next   = abs_sum_ff + evg_pkg::SumWidth'(item.mag);
      chunk_done = fill_inc >= chunk_eff;
      strength   = evg_pkg::bit_length(sum_next);
      voiced     = strength >= cfg.strength_threshold;

      if (voiced) begin
         hang_next = $signed({1'b0, cfg.hangover_chunks});
      end else if (hang_ff != HangFloor) begin
         hang_next = hang_ff - evg_pkg::HangWidth'(1);
      end else begin
         hang_next = hang_ff;
      end

      samples_next = samples_ff + evg_pkg::TotalWidth'(chunk_eff);
      chunks_next  = chunks_ff + evg_pkg::TotalWidth'(1);
      room         = BufferLimit - (evg_pkg::TotalWidth + 1)'(chunk_eff);
      ends = !((hang_next > $signed(evg_pkg::HangWidth'(0)))
               && ((evg_pkg::TotalWidth + 1)'(samples_next) < room));

      produce  = (item.operation == evg_pkg::OpStop) || chunk_done;
      out_free = !valid_ff || rsp_ready;
      consume  = item_valid && (out_free || !produce);

      abs_sum_in = abs_sum_ff;
      fill_in    = fill_ff;
      samples_in = samples_ff;
      chunks_in  = chunks_ff;
      hang_in    = hang_ff;
      report_in  = report_ff;
      valid_in   = valid_ff && !rsp_ready;

      if (consume) begin
         if (item.operation == evg_pkg::OpStop) begin
            report_in.strength        = '0;
            report_in.voiced          = 1'b0;
            report_in.session_end     = 1'b1;
            report_in.keep            = samples_ff != '0;
            report_in.session_samples = samples_ff;
            report_in.session_chunks  = chunks_ff;
            valid_in   = 1'b1;
            abs_sum_in = '0;
            fill_in    = '0;
            samples_in = '0;
            chunks_in  = '0;
            hang_in    = '0;
         end else if (chunk_done) begin
            report_in.strength        = strength;
            report_in.voiced          = voiced;
            report_in.session_end     = ends;
            report_in.keep            = ends && (chunks_next >=
                                        evg_pkg::TotalWidth'(cfg.min_session_chunks));
            report_in.session_samples = samples_next;
            report_in.session_chunks  = chunks_next;
            valid_in   = 1'b1;
            abs_sum_in = '0;
            fill_in    = '0;
            samples_in = ends ? '0 : samples_next;
            chunks_in  = ends ? '0 : chunks_next;
            hang_in    = ends ? '0 : hang_next;
         end else begin
            abs_sum_in = sum_next;
            fill_in    = fill_inc[evg_pkg::FillWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_sum_ff <= '0;
         fill_ff    <= '0;
         samples_ff <= '0;
         chunks_ff  <= '0;
         hang_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         abs_sum_ff <= abs_sum_in;
         fill_ff    <= fill_in;
         samples_ff <= samples_in;
         chunks_ff  <= chunks_in;
         hang_ff    <= hang_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      report_ff <= report_in;
   end

   assign rsp_valid = valid_ff;
   assign report    = report_ff;

endmodule
